@@ design/bilinear_upscale_2x_core_defines.svh @@
// Assertion macros shared by the bilinear upscale core.
// Each macro checks on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef BILINEAR_UPSCALE_2X_CORE_DEFINES_SVH
`define BILINEAR_UPSCALE_2X_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// cond must never be true
`define BUP2X_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("bup2x: forbidden condition seen");

// ante implies cons in the same cycle
`define BUP2X_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bup2x: implication failed");

// ante implies cons in the next cycle
`define BUP2X_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bup2x: next-cycle implication failed");

`else

`define BUP2X_NEVER(label, cond)
`define BUP2X_IMPLIES(label, ante, cons)
`define BUP2X_NEXT(label, ante, cons)

`endif

`endif

@@ design/bup2x_pkg.sv @@
package bup2x_pkg;

    localparam int COORD_W    = 10;
    localparam int CH_W       = 8;
    localparam int TILE_REG_W = 10;

    localparam logic [TILE_REG_W-1:0] TILE_RESET = 10'd512;

    // configuration register index
    localparam logic CFG_TILE_WIDTH  = 1'b0;
    localparam logic CFG_TILE_HEIGHT = 1'b1;

    // anchors an input pixel may complete, in emission order
    localparam logic [1:0] ANC_UL = 2'd0;
    localparam logic [1:0] ANC_UR = 2'd1;
    localparam logic [1:0] ANC_LL = 2'd2;
    localparam logic [1:0] ANC_LR = 2'd3;

    // position of a result within its anchor's 2x2 block
    localparam logic [1:0] SUB_CORNER = 2'd0;
    localparam logic [1:0] SUB_HORIZ  = 2'd1;
    localparam logic [1:0] SUB_VERT   = 2'd2;
    localparam logic [1:0] SUB_DIAG   = 2'd3;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [COORD_W-1:0] col2;   // 2 * column, wrapped
        logic [COORD_W-1:0] row2;   // 2 * row, wrapped
        t_pix               cur;
        t_pix               above;
        t_pix               left;
        t_pix               upper_left;
        logic [3:0]         mask;   // one bit per anchor code
    } t_job;

    typedef struct packed {
        logic emit;
        logic last;
        logic pop;
    } t_back_stat;

endpackage

@@ design/bilinear_upscale_2x_core.sv @@
// 2x bilinear upscaler for RGB tiles sent in raster order, one source pixel per request.
// Every source pixel is the anchor of a 2x2 output block: the corner copies it, the right
// and lower outputs take the truncated mean with that neighbor, the diagonal takes the
// truncated mean of all four; neighbors past the tile edge count as zero. An anchor's
// block leaves once its lower-right neighbor arrives, so results trail the input by one
// row and one pixel, and the last pixel of a tile releases up to 16 results. Results come
// out anchor by anchor in raster order within each request, each block as corner, right,
// lower, diagonal, with run_last set on the final result of a request. The output side
// moves one result per cycle unless i_ready stalls it; first-row pixels release nothing
// unless the tile is one row high. The input side takes one request per cycle until the
// four-entry job queue in front of the output sequencer fills. Results pass through the
// stage register, job queue and output register. Program tile_width and tile_height
// (1..MAX_WIDTH, 1..MAX_HEIGHT, out-of-range values saturate) while the block is idle.
`include "bilinear_upscale_2x_core_defines.svh"

module bilinear_upscale_2x_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [bup2x_pkg::TILE_REG_W-1:0]  i_cfg_data,
    // source pixel requests
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [bup2x_pkg::CH_W-1:0]        i_blue_in,
    input  logic [bup2x_pkg::CH_W-1:0]        i_green_in,
    input  logic [bup2x_pkg::CH_W-1:0]        i_red_in,
    // upscaled results
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bup2x_pkg::COORD_W-1:0]     o_out_col,
    output logic [bup2x_pkg::COORD_W-1:0]     o_out_row,
    output logic [bup2x_pkg::CH_W-1:0]        o_blue_out,
    output logic [bup2x_pkg::CH_W-1:0]        o_green_out,
    output logic [bup2x_pkg::CH_W-1:0]        o_red_out,
    output logic                              o_run_last
);
    import bup2x_pkg::*;

    logic [TILE_REG_W-1:0] r_tile_width, r_tile_height;

    t_pix       w_in_pix, w_out_pix;
    t_job       w_job, w_head;
    logic       w_push, w_full, w_empty, w_pop;
    t_back_stat w_bstat;

    // hold the tile geometry; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= TILE_RESET;
            r_tile_height <= TILE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_data;
                CFG_TILE_HEIGHT: r_tile_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_pix.blue  = i_blue_in;
    assign w_in_pix.green = i_green_in;
    assign w_in_pix.red   = i_red_in;

    // front: track position, read and update the line store, classify anchors
    bup2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tile_width  (r_tile_width),
        .i_tile_height (r_tile_height),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pix         (w_in_pix),
        .o_push        (w_push),
        .o_job         (w_job),
        .i_full        (w_full)
    );

    // decouple classification from result emission
    bup2x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // back: walk the anchors of each job, one result per cycle while the output is free
    bup2x_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_stat  (w_bstat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_col   (o_out_col),
        .o_row   (o_out_row),
        .o_pix   (w_out_pix),
        .o_last  (o_run_last)
    );

    assign o_blue_out  = w_out_pix.blue;
    assign o_green_out = w_out_pix.green;
    assign o_red_out   = w_out_pix.red;

    // a job leaves the queue when its final result is emitted
    `BUP2X_IMPLIES(a_last_pops, w_bstat.emit && w_bstat.last, w_bstat.pop)
    // never drain an empty queue
    `BUP2X_NEVER(a_pop_empty, w_bstat.pop && w_empty)
    // an emitted result lands in the output register
    `BUP2X_NEXT(a_emit_loads, w_bstat.emit, o_valid)

endmodule

@@ design/bup2x_front.sv @@
module bup2x_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bup2x_pkg::TILE_REG_W-1:0]  i_tile_width,
    input  logic [bup2x_pkg::TILE_REG_W-1:0]  i_tile_height,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bup2x_pkg::t_pix                   i_pix,
    output logic                              o_push,
    output bup2x_pkg::t_job                   o_job,
    input  logic                              i_full
);
    import bup2x_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC = (CW > TILE_REG_W) ? CW : TILE_REG_W;
    localparam int HC = (RW > TILE_REG_W) ? RW : TILE_REG_W;

    t_pix r_row_store [MAX_WIDTH];

    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    t_pix               r_left, r_upper_left;
    logic               r_s1_valid;
    t_pix               r_s1_cur, r_s1_left, r_above;
    logic [COORD_W-1:0] r_s1_col2, r_s1_row2;
    logic [3:0]         r_s1_mask;

    logic [WC-1:0] tw_ext;
    logic [HC-1:0] th_ext;
    logic [CW-1:0] w_eff, cx;
    logic [RW-1:0] h_eff, row_step, cy;
    logic          wrap_col, last_col, last_row, accept;
    logic [3:0]    mask;
    logic [AW-1:0] addr;

    always_comb begin
        tw_ext = WC'(i_tile_width);
        th_ext = HC'(i_tile_height);
        priority if (tw_ext == '0) begin
            w_eff = CW'(1);
        end else if (tw_ext > WC'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(tw_ext);
        end
        priority if (th_ext == '0) begin
            h_eff = RW'(1);
        end else if (th_ext > HC'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(th_ext);
        end

        // a column beyond the current width starts the next row
        wrap_col = (r_col >= w_eff);
        row_step = wrap_col ? r_row + RW'(1) : r_row;
        cx       = wrap_col ? '0 : r_col;
        cy       = (row_step >= h_eff) ? '0 : row_step;
        last_col = (cx == w_eff - CW'(1));
        last_row = (cy == h_eff - RW'(1));
        addr     = cx[AW-1:0];

        mask         = '0;
        mask[ANC_UL] = (cy != '0) && (cx != '0);
        mask[ANC_UR] = (cy != '0) && last_col;
        mask[ANC_LL] = last_row && (cx != '0);
        mask[ANC_LR] = last_row && last_col;

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : cy + RW'(1);
        end else begin
            n_col = cx + CW'(1);
            n_row = cy;
        end
    end

    assign o_ready = !r_s1_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_s1_valid && !i_full;

    // read-first line store: old entry goes to r_above, new pixel replaces it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above           <= r_row_store[addr];
            r_row_store[addr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_upper_left <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_col      <= n_col;
                r_row      <= n_row;
                r_left     <= i_pix;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (o_push) begin
                r_upper_left <= r_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur  <= i_pix;
            r_s1_left <= r_left;
            r_s1_col2 <= COORD_W'({cx, 1'b0});
            r_s1_row2 <= COORD_W'({cy, 1'b0});
            r_s1_mask <= mask;
        end
    end

    always_comb begin
        o_job.col2       = r_s1_col2;
        o_job.row2       = r_s1_row2;
        o_job.cur        = r_s1_cur;
        o_job.above      = r_above;
        o_job.left       = r_s1_left;
        o_job.upper_left = r_upper_left;
        o_job.mask       = r_s1_mask;
    end

endmodule

@@ design/bup2x_queue.sv @@
module bup2x_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bup2x_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output bup2x_pkg::t_job o_head,
    output logic            o_empty
);
    import bup2x_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // depth is a power of two: pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW + 1)'(1);
            end
        end
    end

endmodule

@@ design/bup2x_back.sv @@
module bup2x_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bup2x_pkg::t_job                 i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    output bup2x_pkg::t_back_stat           o_stat,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bup2x_pkg::COORD_W-1:0]   o_col,
    output logic [bup2x_pkg::COORD_W-1:0]   o_row,
    output bup2x_pkg::t_pix                 o_pix,
    output logic                            o_last
);
    import bup2x_pkg::*;

    function automatic logic [CH_W-1:0] mix(
        input logic [1:0]      sub,
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] e
    );
        logic [CH_W:0]   sh;
        logic [CH_W:0]   sv;
        logic [CH_W+1:0] sd;
        logic [CH_W-1:0] res;
        sh = (CH_W + 1)'(a) + (CH_W + 1)'(b);
        sv = (CH_W + 1)'(a) + (CH_W + 1)'(c);
        sd = (CH_W + 2)'(a) + (CH_W + 2)'(b) + (CH_W + 2)'(c) + (CH_W + 2)'(e);
        unique case (sub)
            SUB_CORNER: res = a;
            SUB_HORIZ:  res = sh[CH_W:1];
            SUB_VERT:   res = sv[CH_W:1];
            SUB_DIAG:   res = sd[CH_W+1:2];
            default:    res = a;
        endcase
        return res;
    endfunction

    logic [1:0] r_anc, r_sub;
    logic       r_o_valid;
    logic [COORD_W-1:0] r_o_col, r_o_row;
    t_pix       r_o_pix;
    logic       r_o_last;

    logic [3:0] avail, rest;
    logic [1:0] cur_anc;
    logic       more, out_free, emit, drop, pop, last;
    t_pix       c00, c10, c01, c11, mixed;
    logic [COORD_W-1:0] col_base, row_base;

    always_comb begin
        avail = i_head.mask & (4'b1111 << r_anc);
        priority if (avail[ANC_UL]) begin
            cur_anc = ANC_UL;
        end else if (avail[ANC_UR]) begin
            cur_anc = ANC_UR;
        end else if (avail[ANC_LL]) begin
            cur_anc = ANC_LL;
        end else begin
            cur_anc = ANC_LR;
        end
        rest     = avail & ~(4'b0001 << cur_anc);
        more     = |rest;
        out_free = !r_o_valid || i_ready;
        // a job with no anchors is dropped without a result
        drop     = !i_empty && !(|avail);
        emit     = !i_empty && (|avail) && out_free;
        last     = (r_sub == SUB_DIAG) && !more;
        pop      = drop || (emit && last);

        unique case (cur_anc)
            ANC_UL: begin
                c00 = i_head.upper_left;
                c10 = i_head.above;
                c01 = i_head.left;
                c11 = i_head.cur;
                col_base = i_head.col2 - COORD_W'(2);
                row_base = i_head.row2 - COORD_W'(2);
            end
            ANC_UR: begin
                c00 = i_head.above;
                c10 = '0;
                c01 = i_head.cur;
                c11 = '0;
                col_base = i_head.col2;
                row_base = i_head.row2 - COORD_W'(2);
            end
            ANC_LL: begin
                c00 = i_head.left;
                c10 = i_head.cur;
                c01 = '0;
                c11 = '0;
                col_base = i_head.col2 - COORD_W'(2);
                row_base = i_head.row2;
            end
            default: begin
                c00 = i_head.cur;
                c10 = '0;
                c01 = '0;
                c11 = '0;
                col_base = i_head.col2;
                row_base = i_head.row2;
            end
        endcase

        mixed.blue  = mix(r_sub, c00.blue, c10.blue, c01.blue, c11.blue);
        mixed.green = mix(r_sub, c00.green, c10.green, c01.green, c11.green);
        mixed.red   = mix(r_sub, c00.red, c10.red, c01.red, c11.red);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anc     <= ANC_UL;
            r_sub     <= SUB_CORNER;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_anc <= ANC_UL;
                r_sub <= SUB_CORNER;
            end else if (emit) begin
                if (r_sub == SUB_DIAG) begin
                    r_anc <= cur_anc + 2'd1;
                    r_sub <= SUB_CORNER;
                end else begin
                    r_anc <= cur_anc;
                    r_sub <= r_sub + 2'd1;
                end
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_col  <= col_base + {{(COORD_W - 1){1'b0}}, r_sub[0]};
            r_o_row  <= row_base + {{(COORD_W - 1){1'b0}}, r_sub[1]};
            r_o_pix  <= mixed;
            r_o_last <= last;
        end
    end

    assign o_pop       = pop;
    assign o_stat.emit = emit;
    assign o_stat.last = last;
    assign o_stat.pop  = pop;
    assign o_valid     = r_o_valid;
    assign o_col       = r_o_col;
    assign o_row       = r_o_row;
    assign o_pix       = r_o_pix;
    assign o_last      = r_o_last;

endmodule
